[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the dirty map.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define GTDM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GTDM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/gtdm_pkg.sv]
// Package for the generation-tagged dirty map: widths, codes and defaults.
package gtdm_pkg;

   localparam int TAG_BITS   = 8;
   localparam int SECTOR_W   = 23;
   localparam int COUNT_W    = 17;
   localparam int DISK_W     = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   localparam int DEFAULT_CHUNK_SECTORS = 2048;
   localparam int DEFAULT_NUM_CHUNKS    = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_GENERATION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_SECTORS       = 1'b1;

   localparam logic [TAG_BITS-1:0] GEN_RESET  = 8'd1;
   localparam logic [DISK_W-1:0]   DISK_RESET = 24'd8388608;

   localparam logic MODE_MARK  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

endpackage

[rtl/core/gtdm_if.sv]
// Channel interfaces of the dirty map: request, response and register write.
interface gtdm_req_if;
   import gtdm_pkg::*;
   logic                valid;
   logic                ready;
   logic                mode;
   logic [SECTOR_W-1:0] sector;
   logic [COUNT_W-1:0]  sector_count;
   logic [TAG_BITS-1:0] target_generation;

   modport source (output valid, mode, sector, sector_count, target_generation,
                   input ready);
   modport sink   (input valid, mode, sector, sector_count, target_generation,
                   output ready);
endinterface

interface gtdm_rsp_if;
   import gtdm_pkg::*;
   logic                valid;
   logic                ready;
   logic                is_dirty;
   logic [TAG_BITS-1:0] chunk_generation;

   modport source (output valid, is_dirty, chunk_generation, input ready);
   modport sink   (input valid, is_dirty, chunk_generation, output ready);
endinterface

interface gtdm_csr_if;
   import gtdm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/generation_tagged_dirty_map.sv]
// Generation-tagged dirty map: per-chunk dirty bit and tag in one memory.
//
// req_chan carries mark items (mode 0: sector range) and query items
// (mode 1: one sector). Every item yields exactly one transfer on rsp_chan;
// marks answer with both fields 0. csr_chan writes current_generation
// (index 0) and disk_sectors (index 1); it is always ready. The user must
// see that it is written only while the block is idle; the block itself
// does not enforce this. Sector-to-chunk indexes come from a reciprocal
// multiply with one correction step (states MUL, FIX, CORR), for the first
// and last chunk in parallel. A query does one memory read in DISP, then
// QDATA loads its result; a mark walks the chunks touched in MARK, writing
// one memory entry per cycle. Both end in RESP, which loads the output
// register. The next request is taken in the cycle after the result is
// loaded, while that result may still wait. If the receiver stalls, a
// finished item holds until the output register frees up. After reset a
// clearing pass writes all NUM_CHUNKS entries, one per cycle, before the
// first request is taken; csr writes are taken throughout.
module generation_tagged_dirty_map #(
   parameter int CHUNK_SECTORS = gtdm_pkg::DEFAULT_CHUNK_SECTORS,
   parameter int NUM_CHUNKS    = gtdm_pkg::DEFAULT_NUM_CHUNKS
) (
   input  logic       clock,
   input  logic       reset,
   gtdm_req_if.sink   req_chan,
   gtdm_rsp_if.source rsp_chan,
   gtdm_csr_if.sink   csr_chan
);
   import gtdm_pkg::*;

   `include "assert_macros.svh"

   localparam int X_W     = DISK_W;
   localparam int Q_W     = DISK_W;
   localparam int CS_LOG  = $clog2(CHUNK_SECTORS);
   localparam int SHIFT   = X_W + CS_LOG;
   localparam int P_W     = 2 * X_W + 1;
   localparam int QC_W    = Q_W + 17;
   localparam int IDX_W   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int ENTRY_W = TAG_BITS + 1;
   localparam longint unsigned RECIP = (64'd1 << SHIFT) / CHUNK_SECTORS;
   localparam logic [Q_W-1:0]  LAST_CHUNK   = Q_W'(NUM_CHUNKS - 1);
   localparam logic [Q_W-1:0]  NUM_CHUNKS_Q = Q_W'(NUM_CHUNKS);
   localparam logic [QC_W-1:0] CS_QC        = QC_W'(CHUNK_SECTORS);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MUL, ST_FIX, ST_CORR, ST_DISP, ST_MARK, ST_QDATA, ST_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [Q_W-1:0]      cur_ff, cur_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TAG_BITS-1:0] gen_ff, gen_in;
   logic [DISK_W-1:0]   disk_ff, disk_in;

   logic                mode_ff, mode_in;
   logic [SECTOR_W-1:0] sector_ff, sector_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TAG_BITS-1:0] target_ff, target_in;
   logic [X_W-1:0]      x_ff [2];
   logic [X_W-1:0]      x_in [2];
   logic [P_W-1:0]      p_ff [2];
   logic [P_W-1:0]      p_in [2];
   logic [Q_W-1:0]      q0_ff [2];
   logic [Q_W-1:0]      q0_in [2];
   logic [QC_W-1:0]     qc_ff [2];
   logic [QC_W-1:0]     qc_in [2];
   logic [Q_W-1:0]      quo_ff [2];
   logic [Q_W-1:0]      quo_in [2];
   logic                res_dirty_ff, res_dirty_in;
   logic [TAG_BITS-1:0] res_gen_ff, res_gen_in;
   logic                rsp_dirty_ff, rsp_dirty_in;
   logic [TAG_BITS-1:0] rsp_gen_ff, rsp_gen_in;

   logic [P_W-1:0]      p_sh [2];
   logic [QC_W-1:0]     rem [2];

   logic [ENTRY_W-1:0]  mem [NUM_CHUNKS];
   logic [ENTRY_W-1:0]  rd_ff;
   logic                mem_we, mem_re;
   logic [IDX_W-1:0]    mem_addr;
   logic [ENTRY_W-1:0]  mem_wdata;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.is_dirty    = rsp_dirty_ff;
   assign rsp_chan.chunk_generation = rsp_gen_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         p_sh[i] = p_ff[i] >> SHIFT;
         rem[i]  = QC_W'(x_ff[i]) - qc_ff[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff;
      gen_in       = gen_ff;
      disk_in      = disk_ff;
      mode_in      = mode_ff;
      sector_in    = sector_ff;
      count_in     = count_ff;
      target_in    = target_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      q0_in        = q0_ff;
      qc_in        = qc_ff;
      quo_in       = quo_ff;
      res_dirty_in = res_dirty_ff;
      res_gen_in   = res_gen_ff;
      rsp_dirty_in = rsp_dirty_ff;
      rsp_gen_in   = rsp_gen_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = cur_ff[IDX_W-1:0];
      mem_wdata    = {1'b1, gen_ff};

      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_CURRENT_GENERATION: gen_in = csr_chan.data[TAG_BITS-1:0];
            CSR_DISK_SECTORS:       disk_in = csr_chan.data[DISK_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (cur_ff == LAST_CHUNK) begin
               state_in = ST_IDLE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in   = req_chan.mode;
               sector_in = req_chan.sector;
               count_in  = req_chan.sector_count;
               target_in = req_chan.target_generation;
               x_in[0]   = X_W'(req_chan.sector);
               x_in[1]   = X_W'(req_chan.sector) + X_W'(req_chan.sector_count) - 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            for (int i = 0; i < 2; i++) begin
               p_in[i] = P_W'(x_ff[i]) * P_W'(RECIP);
            end
            state_in = ST_FIX;
         end
         ST_FIX: begin
            for (int i = 0; i < 2; i++) begin
               q0_in[i] = p_sh[i][Q_W-1:0];
               qc_in[i] = QC_W'(p_sh[i][Q_W-1:0]) * CS_QC;
            end
            state_in = ST_CORR;
         end
         ST_CORR: begin
            for (int i = 0; i < 2; i++) begin
               quo_in[i] = q0_ff[i] + Q_W'(rem[i] >= CS_QC);
            end
            state_in = ST_DISP;
         end
         ST_DISP: begin
            res_dirty_in = 1'b0;
            res_gen_in   = '0;
            if (mode_ff == MODE_QUERY) begin
               if (DISK_W'(sector_ff) >= disk_ff || quo_ff[0] >= NUM_CHUNKS_Q) begin
                  state_in = ST_RESP;
               end else begin
                  mem_re   = 1'b1;
                  mem_addr = quo_ff[0][IDX_W-1:0];
                  state_in = ST_QDATA;
               end
            end else begin
               if (count_ff == '0 || quo_ff[0] >= NUM_CHUNKS_Q) begin
                  state_in = ST_RESP;
               end else begin
                  cur_in   = quo_ff[0];
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            mem_we = 1'b1;
            if (cur_ff == quo_ff[1] || cur_ff == LAST_CHUNK) begin
               state_in = ST_RESP;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         ST_QDATA: begin
            res_gen_in   = rd_ff[TAG_BITS-1:0];
            res_dirty_in = rd_ff[TAG_BITS] && (rd_ff[TAG_BITS-1:0] < target_ff);
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dirty_in = res_dirty_ff;
               rsp_gen_in   = res_gen_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      sector_ff    <= sector_in;
      count_ff     <= count_in;
      target_ff    <= target_in;
      x_ff         <= x_in;
      p_ff         <= p_in;
      q0_ff        <= q0_in;
      qc_ff        <= qc_in;
      quo_ff       <= quo_in;
      res_dirty_ff <= res_dirty_in;
      res_gen_ff   <= res_gen_in;
      rsp_dirty_ff <= rsp_dirty_in;
      rsp_gen_ff   <= rsp_gen_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         gen_ff       <= GEN_RESET;
         disk_ff      <= DISK_RESET;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_ff       <= gen_in;
         disk_ff      <= disk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

   `GTDM_ASSERT(a_walk_in_store, (state_ff == ST_MARK || state_ff == ST_CLEAR) |-> cur_ff <= LAST_CHUNK, "chunk walk left the store")
   `GTDM_ASSERT(a_range_order, (state_ff == ST_DISP && mode_ff == MODE_MARK && count_ff != '0) |-> quo_ff[0] <= quo_ff[1], "first chunk beyond last chunk")
   `GTDM_ASSERT(a_rsp_from_resp, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP, "response loaded outside result state")
   `GTDM_ASSERT_ALWAYS(a_no_req_in_reset, reset |=> !req_chan.ready, "request taken during clearing pass")

endmodule
